// ----- sv/hfc_pkg.sv -----
// ----------------------------------------------------------------------------
// hfc_pkg
// Shared types, constants and the CRC-8 byte update for the frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package hfc_pkg;

    localparam logic [7:0]  CRC_POLY = 8'h31;
    localparam logic [7:0]  CRC_INIT = 8'hFF;

    localparam int unsigned TEMP_SCALE  = 17500;
    localparam int unsigned HUM_SCALE   = 10000;
    localparam int unsigned TEMP_OFFSET = 4500;

    localparam int unsigned TEMP_Q_W = $clog2(TEMP_SCALE + 1);
    localparam int unsigned HUM_Q_W  = $clog2(HUM_SCALE + 1);

    // Byte positions inside one frame
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } rx_word_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic [15:0]        raw_temperature;
        logic [15:0]        raw_humidity;
        logic               temperature_crc_ok;
        logic               humidity_crc_ok;
        logic               frame_ok;
    } result_word_t;

    // Input stage to frame tracker
    typedef struct packed {
        logic     valid;
        rx_word_t data;
    } held_byte_t;

    // Advance the CRC by one byte, MSB first, no reflection.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/hfc_stream_if.sv -----
// ----------------------------------------------------------------------------
// hfc_stream_if
// Valid/ready channel carrying one word of a generic payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface hfc_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/hfc_byte_stage.sv -----
// ----------------------------------------------------------------------------
// hfc_byte_stage
// Input register: capture one received word, hold it until the tracker takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module hfc_byte_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire hfc_pkg::rx_word_t in_data,
    output logic                   in_ready,
    input  wire logic              take,
    output hfc_pkg::held_byte_t    held
);
    import hfc_pkg::*;

    logic     valid_reg, valid_next;
    rx_word_t data_reg;
    logic     load;

    assign in_ready = !valid_reg || take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= in_data;
        end
    end

    assign held.valid = valid_reg;
    assign held.data  = data_reg;

endmodule

`default_nettype wire

// ----- sv/hfc_scale.sv -----
// ----------------------------------------------------------------------------
// hfc_scale
// Compute floor(SCALE * raw / 65535) with one constant multiply and one fixup.
// ----------------------------------------------------------------------------
`default_nettype none

module hfc_scale #(
    parameter int unsigned SCALE = 10000,
    parameter int unsigned Q_W   = $clog2(SCALE + 1)
) (
    input  wire logic [15:0]  raw,
    output logic [Q_W-1:0]    scaled
);
    localparam int unsigned S_W   = $clog2(SCALE + 1);
    localparam int unsigned P_W   = 16 + S_W;
    localparam int unsigned HI_W  = P_W - 16;
    localparam int unsigned REM_W = ((HI_W > 16) ? HI_W : 16) + 1;

    logic [P_W-1:0]   prod;
    logic [HI_W-1:0]  q0;
    logic [REM_W-1:0] rem;
    logic [HI_W-1:0]  q;

    // x = q0*65536 + lo = q0*65535 + (lo + q0); the true quotient is q0 or q0+1
    assign prod = P_W'(raw) * P_W'(SCALE);
    assign q0   = prod[P_W-1:16];
    assign rem  = REM_W'(prod[15:0]) + REM_W'(q0);
    assign q    = (rem >= REM_W'(16'hFFFF)) ? q0 + HI_W'(1) : q0;

    assign scaled = Q_W'(q);

endmodule

`default_nettype wire

// ----- sv/hfc_frame_track.sv -----
// ----------------------------------------------------------------------------
// hfc_frame_track
// Byte position, running CRC and word capture; loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hfc_frame_track (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire hfc_pkg::held_byte_t  held,
    output logic                      take,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output hfc_pkg::result_word_t     out_data
);
    import hfc_pkg::*;

    logic [2:0]   pos_reg, pos_next;
    logic [7:0]   crc_reg, crc_next;
    logic [15:0]  temp_word_reg, temp_word_next;
    logic [15:0]  hum_word_reg, hum_word_next;
    logic         t_good_reg, t_good_next;
    logic         out_valid_reg, out_valid_next;
    result_word_t result_reg;

    logic [2:0]   pos_eff;
    logic [7:0]   b;
    logic [7:0]   crc_fed;
    logic         last_byte;
    logic         hum_ok;

    logic [TEMP_Q_W-1:0] temp_q;
    logic [HUM_Q_W-1:0]  hum_q;
    logic signed [TEMP_Q_W:0] temp_signed;

    hfc_scale #(.SCALE(TEMP_SCALE), .Q_W(TEMP_Q_W)) u_temp_scale (
        .raw    (temp_word_reg),
        .scaled (temp_q)
    );

    hfc_scale #(.SCALE(HUM_SCALE), .Q_W(HUM_Q_W)) u_hum_scale (
        .raw    (hum_word_reg),
        .scaled (hum_q)
    );

    assign b = held.data.rx_byte;

    // Resync on frame start, and treat unused positions as the first byte
    assign pos_eff = (held.data.frame_start || pos_reg > POS_H_CRC) ? POS_T_HI : pos_reg;

    assign crc_fed   = crc8_feed((pos_eff == POS_T_HI || pos_eff == POS_H_HI) ? CRC_INIT : crc_reg, b);
    assign last_byte = (pos_eff == POS_H_CRC);
    assign hum_ok    = (crc_reg == b);

    // Stall only a closing byte while the previous result is still held
    assign take = held.valid && (!last_byte || !out_valid_reg || out_ready);

    assign temp_signed = $signed({1'b0, temp_q}) - $signed((TEMP_Q_W + 1)'(TEMP_OFFSET));

    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        temp_word_next = temp_word_reg;
        hum_word_next  = hum_word_reg;
        t_good_next    = t_good_reg;
        if (take)
        begin
            pos_next = last_byte ? POS_T_HI : pos_eff + 3'd1;
            unique case (pos_eff)
                POS_T_HI:
                begin
                    crc_next       = crc_fed;
                    temp_word_next = {b, temp_word_reg[7:0]};
                end
                POS_T_LO:
                begin
                    crc_next       = crc_fed;
                    temp_word_next = {temp_word_reg[15:8], b};
                end
                POS_T_CRC:
                begin
                    t_good_next = (crc_reg == b);
                    crc_next    = CRC_INIT;
                end
                POS_H_HI:
                begin
                    crc_next      = crc_fed;
                    hum_word_next = {b, hum_word_reg[7:0]};
                end
                POS_H_LO:
                begin
                    crc_next      = crc_fed;
                    hum_word_next = {hum_word_reg[15:8], b};
                end
                default:
                begin
                    crc_next = CRC_INIT;
                end
            endcase
        end
    end

    always_comb
    begin
        if (take && last_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_T_HI;
            crc_reg       <= CRC_INIT;
            temp_word_reg <= 16'h0000;
            hum_word_reg  <= 16'h0000;
            t_good_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_word_reg <= temp_word_next;
            hum_word_reg  <= hum_word_next;
            t_good_reg    <= t_good_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && last_byte)
        begin
            result_reg.temperature_centi  <= temp_signed[14:0];
            result_reg.humidity_centi     <= hum_q;
            result_reg.raw_temperature    <= temp_word_reg;
            result_reg.raw_humidity       <= hum_word_reg;
            result_reg.temperature_crc_ok <= t_good_reg;
            result_reg.humidity_crc_ok    <= hum_ok;
            result_reg.frame_ok           <= t_good_reg && hum_ok;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;

endmodule

`default_nettype wire

// ----- sv/humidity_frame_checker.sv -----
// ----------------------------------------------------------------------------
// humidity_frame_checker
// Checks the CRC-8 of a six-byte humidity/temperature frame and converts it.
//
// Usage:
//   rx carries one received byte per word, with frame_start marking the
//   first byte of a frame; it resynchronizes the byte position at any time
//   and drops a partial frame. Bytes come temperature high, low, CRC, then
//   humidity high, low, CRC. Each word's CRC is polynomial 0x31, seed 0xFF.
//   After the sixth byte one word leaves on result: raw words, CRC flags,
//   frame_ok, and both conversions in hundredths (floor of the scaled raw).
//   A bad CRC still yields a result; only the flags show it.
//   Flow: the sixth byte is loaded into the input register; once the frame
//   tracker takes it, the result register is loaded and result turns valid.
//   Throughput: one byte per cycle while no closing byte is stalled, at most
//   one result per six bytes. The path is set by one constant multiply and
//   remainder fixup per conversion.
//   Stall: while result waits, bytes one to five keep flowing; a closing
//   byte is held in the input register until the result is taken.
//   Reset: rst_n clears the position, seeds the CRC and empties both stages.
// ----------------------------------------------------------------------------
`default_nettype none

module humidity_frame_checker (
    input  wire logic   clk,
    input  wire logic   rst_n,
    hfc_stream_if.sink   rx,
    hfc_stream_if.source result
);
    import hfc_pkg::*;

    held_byte_t held;
    logic       take;

    // Input register: parts the sender from the frame logic
    hfc_byte_stage u_byte_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_data  (rx.data),
        .in_ready (rx.ready),
        .take     (take),
        .held     (held)
    );

    // Frame tracking, CRC, conversions and the result register
    hfc_frame_track u_frame_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .held      (held),
        .take      (take),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (result.data)
    );

endmodule

`default_nettype wire

// ----- sv/hfc_checker.sv -----
// ----------------------------------------------------------------------------
// hfc_checker
// Port-level checks for the frame checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hfc_checker (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  result_valid,
    input  wire logic                  result_ready,
    input  wire hfc_pkg::result_word_t result_data
);
    import hfc_pkg::*;

    // Hold a result until it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_data))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.frame_ok ==
            (result_data.temperature_crc_ok && result_data.humidity_crc_ok)))
        else $error("frame_ok disagrees with CRC flags");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.humidity_centi <= 14'd10000
            && result_data.temperature_centi >= -15'sd4500
            && result_data.temperature_centi <= 15'sd13000))
        else $error("conversion out of range");

endmodule

bind humidity_frame_checker hfc_checker u_hfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

`default_nettype wire

// ----- test/humidity_frame_checker_test.sv -----
// ----------------------------------------------------------------------------
// humidity_frame_checker_test
// Self-checking testbench for the sensor frame checker: feeds received bytes
// through the rx channel, predicts every reading from its own frame decoder,
// and compares each result word field by field under random stalls.
// ----------------------------------------------------------------------------

module humidity_frame_checker_test;

    timeunit 1ns;
    timeprecision 1ps;

    import hfc_pkg::*;

    localparam int unsigned STALL_PERCENT  = 25;
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 20;
    localparam int unsigned PRINT_CAP      = 200;

    logic clk;
    logic rst_n;

    hfc_stream_if #(.payload_t(rx_word_t))     rx_ch ();
    hfc_stream_if #(.payload_t(result_word_t)) result_ch ();

    humidity_frame_checker dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (result_ch)
    );

    // Frame decoder state, kept apart from the block under test
    logic [2:0]   model_pos;
    logic [7:0]   model_crc;
    logic [15:0]  model_temp_word;
    logic [15:0]  model_hum_word;
    logic         model_temp_good;

    result_word_t pending_readings[$];

    int unsigned  error_count;
    int unsigned  bytes_sent;
    int unsigned  quiet_cycles;
    bit           steady;      // 1: neither side idles

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Decoder helpers
    // ------------------------------------------------------------------------

    // CRC-8, polynomial 0x31, MSB first: one byte at a time.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] acc;
        logic       top;
        acc = crc;
        for (int i = 7; i >= 0; i--)
        begin
            top = acc[7] ^ b[i];
            acc = {acc[6:0], 1'b0};
            if (top)
            begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc8_step(crc8_step(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    // Advance the decoder by one accepted byte; return 1 with the reading
    // when the byte closes a frame.
    function automatic bit decode_rx_byte(input logic [7:0] b, input logic fs,
                                          output result_word_t reading);
        logic [2:0]  pos;
        logic        hum_good;
        int unsigned temp_q;
        int unsigned hum_q;
        pos = model_pos;
        reading = '0;
        // Resync on frame_start; treat unreachable positions as the first
        if (fs || pos > POS_H_CRC)
        begin
            pos = POS_T_HI;
            model_crc = CRC_INIT;
        end
        case (pos)
            POS_T_HI:
            begin
                model_crc = crc8_step(CRC_INIT, b);
                model_temp_word[15:8] = b;
            end
            POS_T_LO:
            begin
                model_crc = crc8_step(model_crc, b);
                model_temp_word[7:0] = b;
            end
            POS_T_CRC:
            begin
                model_temp_good = (model_crc == b);
                model_crc = CRC_INIT;
            end
            POS_H_HI:
            begin
                model_crc = crc8_step(CRC_INIT, b);
                model_hum_word[15:8] = b;
            end
            POS_H_LO:
            begin
                model_crc = crc8_step(model_crc, b);
                model_hum_word[7:0] = b;
            end
            default:
            begin
            end
        endcase
        if (pos != POS_H_CRC)
        begin
            model_pos = pos + 3'd1;
            return 1'b0;
        end
        hum_good  = (model_crc == b);
        model_crc = CRC_INIT;
        model_pos = POS_T_HI;
        temp_q = (TEMP_SCALE * int'(model_temp_word)) / 65535;
        hum_q  = (HUM_SCALE * int'(model_hum_word)) / 65535;
        reading.temperature_centi  = 15'(int'(temp_q) - int'(TEMP_OFFSET));
        reading.humidity_centi     = 14'(hum_q);
        reading.raw_temperature    = model_temp_word;
        reading.raw_humidity       = model_hum_word;
        reading.temperature_crc_ok = model_temp_good;
        reading.humidity_crc_ok    = hum_good;
        reading.frame_ok           = model_temp_good & hum_good;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        if (error_count <= PRINT_CAP)
        begin
            $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
        end
    endtask

    task automatic compare_field(input string what, input longint got, input longint want);
        if (got != want)
        begin
            report_mismatch(what, got, want);
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitors, sampled at the falling edge where every signal is stable.
    // A word seen with valid and ready high here is taken at the next rising
    // edge.
    // ------------------------------------------------------------------------

    // Predict each accepted byte
    always @(negedge clk)
    begin
        result_word_t reading;
        if (rst_n && rx_ch.valid && rx_ch.ready)
        begin
            if (decode_rx_byte(rx_ch.data.rx_byte, rx_ch.data.frame_start, reading))
            begin
                pending_readings.push_back(reading);
            end
        end
    end

    // Check each accepted result against the oldest prediction
    always @(negedge clk)
    begin
        result_word_t want;
        result_word_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.data;
            if (pending_readings.size() == 0)
            begin
                report_mismatch("unexpected result, raw_temperature", got.raw_temperature, -1);
            end
            else
            begin
                want = pending_readings.pop_front();
                compare_field("temperature_centi", got.temperature_centi,
                              want.temperature_centi);
                compare_field("humidity_centi", got.humidity_centi, want.humidity_centi);
                compare_field("raw_temperature", got.raw_temperature, want.raw_temperature);
                compare_field("raw_humidity", got.raw_humidity, want.raw_humidity);
                compare_field("temperature_crc_ok", got.temperature_crc_ok,
                              want.temperature_crc_ok);
                compare_field("humidity_crc_ok", got.humidity_crc_ok, want.humidity_crc_ok);
                compare_field("frame_ok", got.frame_ok, want.frame_ok);
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a word
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((rx_ch.valid && rx_ch.ready) || (result_ch.valid && result_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("humidity_frame_checker verification failed");
                $finish;
            end
        end
    end

    // Receiver: stall at random unless in a steady stretch
    always @(posedge clk)
    begin
        result_ch.ready <= steady || ($urandom_range(0, 99) >= STALL_PERCENT);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Present one byte, idling at random first; return at the edge that
    // takes it.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        bit took;
        while (!steady && $urandom_range(0, 99) < STALL_PERCENT)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.data  <= '{rx_byte: b, frame_start: fs};
        do
        begin
            @(negedge clk);
            took = rx_ch.ready;
            @(posedge clk);
        end while (!took);
        bytes_sent++;
    endtask

    // Send the first count bytes of a frame; corrupt a CRC byte on request.
    task automatic send_frame(input logic [15:0] temp_raw, input logic [15:0] hum_raw,
                              input bit bad_temp, input bit bad_hum, input bit fs,
                              input int unsigned count);
        logic [7:0] frame [6];
        frame[0] = temp_raw[15:8];
        frame[1] = temp_raw[7:0];
        frame[2] = word_crc(temp_raw) ^ (bad_temp ? 8'($urandom_range(1, 255)) : 8'h00);
        frame[3] = hum_raw[15:8];
        frame[4] = hum_raw[7:0];
        frame[5] = word_crc(hum_raw) ^ (bad_hum ? 8'($urandom_range(1, 255)) : 8'h00);
        for (int i = 0; i < count; i++)
        begin
            send_byte(frame[i], (i == 0) ? fs : 1'b0);
        end
    endtask

    // Raw word biased toward the ends of the range
    function automatic logic [15:0] pick_raw();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            return 16'h0000;
        end
        if (r < 20)
        begin
            return 16'hFFFF;
        end
        return 16'($urandom());
    endfunction

    // Drop valid and hold until every predicted reading has come out
    task automatic hold_until_drained();
        rx_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end while (pending_readings.size() != 0);
    endtask

    // Extremes of both conversions, bad CRCs, back-to-back frames and a
    // resync that lands on the closing byte of a frame.
    task automatic test_directed_frames();
        // lowest temperature, highest humidity, both CRCs good
        send_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1, 6);
        // highest temperature, lowest humidity, bad temperature CRC,
        // follows without frame_start
        send_frame(16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b0, 6);
        // partial frame cut after five bytes: the sixth carries frame_start
        // and opens a new frame instead of closing the old one
        send_frame(16'h1234, 16'h5678, 1'b0, 1'b0, 1'b0, 5);
        send_frame(16'hBEEF, 16'h8000, 1'b0, 1'b1, 1'b1, 6);
    endtask

    // Mostly well-formed frames with random content; the rest broken frames
    // and loose noise bytes.
    task automatic run_mixed_traffic(input int unsigned target);
        int unsigned stop_at;
        int unsigned r;
        int unsigned n;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                send_frame(pick_raw(), pick_raw(), $urandom_range(0, 99) < 10,
                           $urandom_range(0, 99) < 10, $urandom_range(0, 1), 6);
            end
            else if (r < 85)
            begin
                n = $urandom_range(1, 5);
                send_frame(pick_raw(), pick_raw(), 1'b0, 1'b0, $urandom_range(0, 1), n);
                send_frame(pick_raw(), pick_raw(), 1'b0, 1'b0, 1'b1, 6);
            end
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                begin
                    send_byte(8'($urandom()), $urandom_range(0, 99) < 20);
                end
            end
        end
    endtask

    task automatic test_mixed_traffic_with_stalls();
        run_mixed_traffic(900);
    endtask

    // Let the sender wait for every outstanding reading before going on
    task automatic test_pause_for_results();
        send_frame(pick_raw(), pick_raw(), 1'b0, 1'b0, 1'b1, 6);
        hold_until_drained();
        send_frame(pick_raw(), pick_raw(), 1'b1, 1'b1, 1'b0, 6);
    endtask

    // Full-rate stretch: no idling on either side
    task automatic test_back_to_back_no_stalls();
        steady = 1'b1;
        run_mixed_traffic(400);
        steady = 1'b0;
    endtask

    task automatic test_tail_traffic();
        run_mixed_traffic(600);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n           = 1'b0;
        rx_ch.valid     = 1'b0;
        rx_ch.data      = '0;
        result_ch.ready = 1'b0;
        steady          = 1'b0;
        error_count     = 0;
        bytes_sent      = 0;
        quiet_cycles    = 0;
        model_pos       = POS_T_HI;
        model_crc       = CRC_INIT;
        model_temp_word = '0;
        model_hum_word  = '0;
        model_temp_good = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_frames();
        test_pause_for_results();
        test_mixed_traffic_with_stalls();
        hold_until_drained();
        test_back_to_back_no_stalls();
        test_tail_traffic();

        // Drain, then give the pipeline time to show any stray result
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_readings.size() != 0)
        begin
            report_mismatch("readings never delivered", 0, pending_readings.size());
        end

        if (error_count == 0)
        begin
            $display("humidity_frame_checker verification clean");
        end
        else
        begin
            $display("humidity_frame_checker verification failed");
        end
        $finish;
    end

endmodule
